@@ hdl/cbd_pkg.sv @@
// Shared types, opcodes and defaults for the circular buffer deque.
`timescale 1ns / 1ps

package cbd_pkg;

    localparam int CAPACITY_DEF      = 1024;
    localparam int ELEMENT_WIDTH_DEF = 32;

    localparam int OPCODE_W   = 3;
    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 11;
    localparam int COUNT_W    = 11;
    localparam int STATUS_W   = 2;

    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_READ       = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_TAKE       = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_DROP       = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } state_t;

    typedef struct packed {
        logic exec;
        logic load_read;
    } cmd_t;

    typedef struct packed {
        logic read_hit;
    } stat_t;

endpackage

@@ hdl/cbd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/cbd_ctrl.sv @@
// Controller state machine: input and output handshakes and datapath sequencing.
`timescale 1ns / 1ps

module cbd_ctrl
    import cbd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.exec      = 1'b0;
        cmd.load_read = 1'b0;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.exec = 1'b1;
                    // An in-range read passes through S_READ to load the RAM data.
                    state_next = stat.read_hit ? S_READ : S_OUT;
                end
            end
            S_READ:
            begin
                cmd.load_read = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/cbd_datapath.sv @@
// Datapath: front pointer, element count, element store and result registers.
`timescale 1ns / 1ps

module cbd_datapath
    import cbd_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic [OPCODE_W-1:0]   opcode,
    input  logic [VALUE_W-1:0]    value,
    input  logic [POSITION_W-1:0] position,
    output logic [VALUE_W-1:0]    read_data,
    output logic [COUNT_W-1:0]    count,
    output logic                  list_empty,
    output logic [STATUS_W-1:0]   status
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = PTR_W + 1;
    localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

    logic [PTR_W-1:0]         front_reg;
    logic [PTR_W-1:0]         front_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [VALUE_W-1:0]       data_reg;
    logic [COUNT_W-1:0]       res_count_reg;
    logic                     res_empty_reg;
    logic [STATUS_W-1:0]      res_status_reg;
    logic [STATUS_W-1:0]      status_next;

    logic                     full;
    logic                     pos_lt;
    logic [PTR_W-1:0]         pos_ptr;
    logic                     ram_we;
    logic [PTR_W-1:0]         ram_waddr;
    logic [ELEMENT_WIDTH-1:0] ram_wdata;
    logic                     ram_re;
    logic [PTR_W-1:0]         ram_raddr;
    logic [ELEMENT_WIDTH-1:0] ram_rdata;

    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign pos_lt    = (CMP_W'(position) < CMP_W'(count_reg));
    assign pos_ptr   = PTR_W'(position);
    assign ram_wdata = ELEMENT_WIDTH'($signed(value));
    assign ram_raddr = front_reg + pos_ptr;
    assign ram_re    = cmd.exec && stat.read_hit;

    assign stat.read_hit = (opcode == OP_READ) && pos_lt;

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = STAT_OK;
        ram_we      = 1'b0;
        ram_waddr   = front_reg - PTR_W'(1);
        unique case (opcode)
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    ram_we     = cmd.exec;
                    front_next = front_reg - PTR_W'(1);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_BACK:
            begin
                ram_waddr = front_reg + count_reg[PTR_W-1:0];
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    ram_we     = cmd.exec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (count_reg != '0)
                begin
                    front_next = front_reg + PTR_W'(1);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (!pos_lt)
                begin
                    status_next = STAT_RANGE;
                end
            end
            OP_TAKE:
            begin
                if (pos_lt)
                begin
                    count_next = CNT_W'(position);
                end
            end
            OP_DROP:
            begin
                if (pos_lt)
                begin
                    front_next = front_reg + pos_ptr;
                    count_next = count_reg - CNT_W'(position);
                end
                else
                begin
                    front_next = '0;
                    count_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            data_reg       <= '0;
            res_count_reg  <= COUNT_W'(count_next);
            res_empty_reg  <= (count_next == '0);
            res_status_reg <= status_next;
        end
        else if (cmd.load_read)
        begin
            data_reg <= VALUE_W'($signed(ram_rdata));
        end
    end

    cbd_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign read_data  = data_reg;
    assign count      = res_count_reg;
    assign list_empty = res_empty_reg;
    assign status     = res_status_reg;

endmodule

@@ hdl/circular_buffer_deque.sv @@
// Top level of the circular buffer deque: controller, datapath and checks.
//
// One operation enters per transfer on the slave stream; each yields exactly
// one result transfer on the master stream. Input tdata carries the opcode,
// the value to push and a position (read index, or n for take and drop).
// Output tdata carries the read data, the count after the operation, an
// empty flag and a status code (ok, push refused when full, read out of range).
// The result is registered and presented from the output state; an in-range
// read first passes a read state, as it waits on the registered read port of
// the store. The controller takes a new operation only after the result has
// been taken.
// Reset empties the list and clears the front pointer; the store contents
// are left as they are and no clearing pass is needed, since only entries
// inside the count are ever read.
// While the receiver holds tready low, the result stays stable on tdata and
// no new input is taken.
`timescale 1ns / 1ps

module circular_buffer_deque
    import cbd_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // opcode[2:0], value[34:3], position[45:35]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // read_data[31:0], count[42:32],
                                       // list_empty[43], status[45:44]
);

    cmd_t                  cmd;
    stat_t                 stat;
    logic [VALUE_W-1:0]    read_data;
    logic [COUNT_W-1:0]    count;
    logic                  list_empty;
    logic [STATUS_W-1:0]   status;

    cbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cbd_datapath #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .opcode     (s_axis_tdata[2:0]),
        .value      (s_axis_tdata[34:3]),
        .position   (s_axis_tdata[45:35]),
        .read_data  (read_data),
        .count      (count),
        .list_empty (list_empty),
        .status     (status)
    );

    assign m_axis_tdata = {2'b00, status, list_empty, count, read_data};

`ifndef NO_ASSERTIONS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input ready while a result is pending");

    a_single_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted before the result was delivered");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && status == STAT_RANGE) |-> (read_data == '0))
        else $error("out-of-range read returned nonzero data");

    a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_read |-> $past(cmd.exec && stat.read_hit))
        else $error("read data loaded without an in-range read");
`endif

endmodule
